### rtl/core/hflc_pkg.sv
// Shared constants, phase codes and byte-matching functions for the HTTP first-line classifier.
`default_nettype none
package hflc_pkg;

	localparam int unsigned METHOD_COUNT = 8;
	localparam int unsigned MIN_LEN      = 18;

	// Parse phase codes
	localparam logic [2:0] PH_IDLE    = 3'd0;
	localparam logic [2:0] PH_METHOD  = 3'd1;
	localparam logic [2:0] PH_SKIP    = 3'd2;
	localparam logic [2:0] PH_SEARCH  = 3'd3;
	localparam logic [2:0] PH_VERSION = 3'd4;
	localparam logic [2:0] PH_MATCH   = 3'd5;
	localparam logic [2:0] PH_FAIL    = 3'd6;

	// Verdict codes
	localparam logic [1:0] VERDICT_NONE     = 2'd0;
	localparam logic [1:0] VERDICT_REQUEST  = 2'd1;
	localparam logic [1:0] VERDICT_RESPONSE = 2'd2;

	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_ONE   = 8'h31;

	typedef logic [7:0] byte_t;

	// Length of each method name: GET HEAD POST OPTIONS PUT DELETE TRACE CONNECT
	function automatic logic [2:0] name_len(input logic [2:0] idx);
		logic [2:0] len;
		case (idx)
			3'd0: len = 3'd3;
			3'd1: len = 3'd4;
			3'd2: len = 3'd4;
			3'd3: len = 3'd7;
			3'd4: len = 3'd3;
			3'd5: len = 3'd6;
			3'd6: len = 3'd5;
			3'd7: len = 3'd7;
			default: len = 3'd0;
		endcase
		return len;
	endfunction

	// Character of a method name at a position; zero past the end
	function automatic byte_t name_char(input logic [2:0] idx, input logic [2:0] pos);
		logic [55:0] s;
		byte_t       c;
		case (idx)
			3'd0: s = {"GET", 32'h0};
			3'd1: s = {"HEAD", 24'h0};
			3'd2: s = {"POST", 24'h0};
			3'd3: s = "OPTIONS";
			3'd4: s = {"PUT", 32'h0};
			3'd5: s = {"DELETE", 8'h0};
			3'd6: s = {"TRACE", 16'h0};
			3'd7: s = "CONNECT";
			default: s = '0;
		endcase
		c = s[8'd55 - {pos, 3'b000} -: 8];
		return c;
	endfunction

	// Advance the two-way HTTP/1.0 / HTTP/1.1 match by one byte
	function automatic logic [1:0] ver_step(input logic [1:0] alive, input logic [3:0] off,
		input byte_t b);
		logic [55:0] prefix;
		logic [1:0]  keep;
		logic [1:0]  res;
		prefix = "HTTP/1.";
		res    = alive;
		if (off < 4'd7) begin
			if (b != prefix[8'd55 - {off[2:0], 3'b000} -: 8])
				res = 2'b00;
		end else if (off == 4'd7) begin
			keep = {b == CHAR_ONE, b == CHAR_ZERO};
			res  = alive & keep;
		end
		return res;
	endfunction

endpackage
`default_nettype wire

### rtl/core/http_first_line_classifier.sv
// Top level of the HTTP first-line classifier: byte register, match logic and verdict register.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+----------------------------------
//  byte in  | byte_valid / byte_stall     | data_byte, first_byte, last_byte
//  result   | result_valid / result_stall | verdict, method_code
//
// One payload byte is taken per cycle while byte_stall is low; each beat is held in the byte
// register, and its verdict (on a last byte only) is then loaded into the result register,
// so throughput is one beat a cycle unless a waiting verdict stalls a last byte.
// arst_n clears the valid flags and returns the parser to idle.
// A stalled result holds the byte register only when it carries a last byte;
// other beats keep flowing past a waiting verdict.
`default_nettype none
module http_first_line_classifier
	import hflc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       byte_valid,
	output logic            byte_stall,
	input  wire logic [7:0] data_byte,
	input  wire logic       first_byte,
	input  wire logic       last_byte,
	output logic            result_valid,
	input  wire logic       result_stall,
	output logic [1:0]      verdict,
	output logic [2:0]      method_code
);

	// Byte register
	logic       valid_s1;
	byte_t      data_s1;
	logic       first_s1;
	logic       last_s1;

	// Parser state
	logic [4:0] pos_q;
	logic [7:0] method_alive_q;
	logic [2:0] chosen_q;
	logic [1:0] resp_alive_q;
	logic [2:0] phase_q;
	logic [3:0] voff_q;
	logic [1:0] valive_q;

	// Next state and result of the beat in the byte register
	logic [4:0] pos_d;
	logic [7:0] method_alive_d;
	logic [2:0] chosen_d;
	logic [1:0] resp_alive_d;
	logic [2:0] phase_d;
	logic [3:0] voff_d;
	logic [1:0] valive_d;
	logic       res_fire;
	logic [1:0] res_verdict;
	logic [2:0] res_method;

	// Result register
	logic       res_valid_q;
	logic [1:0] verdict_q;
	logic [2:0] method_q;

	logic       out_free;
	logic       advance;
	logic       accept;

	// Move the byte on unless it carries a verdict that has nowhere to go
	assign out_free   = !res_valid_q || !result_stall;
	assign advance    = valid_s1 && (!last_s1 || out_free);
	assign byte_stall = valid_s1 && !advance;
	assign accept     = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1  <= data_byte;
			first_s1 <= first_byte;
			last_s1  <= last_byte;
		end
	end

	// Per-byte parse: method names, skip byte, space search, version compare
	always_comb begin
		logic [4:0] cur_pos;
		logic [2:0] len;
		logic [7:0] bit_mask;
		pos_d          = pos_q;
		method_alive_d = method_alive_q;
		chosen_d       = chosen_q;
		resp_alive_d   = resp_alive_q;
		phase_d        = phase_q;
		voff_d         = voff_q;
		valive_d       = valive_q;
		res_fire       = 1'b0;
		res_verdict    = VERDICT_NONE;
		res_method     = 3'd0;
		cur_pos        = pos_q;
		len            = 3'd0;
		bit_mask       = 8'd0;

		// First byte restarts classification, even mid payload
		if (first_s1) begin
			pos_d          = 5'd0;
			method_alive_d = 8'hFF;
			chosen_d       = 3'd0;
			resp_alive_d   = 2'b11;
			phase_d        = PH_METHOD;
			voff_d         = 4'd0;
			valive_d       = 2'b00;
		end

		if (phase_d == PH_IDLE) begin
			// Byte outside any payload: drop it, but answer a stray last byte
			res_fire = last_s1;
		end else begin
			cur_pos = pos_d;

			// Response signature sits in the first eight bytes
			if (cur_pos < 5'd8)
				resp_alive_d = ver_step(resp_alive_d, {1'b0, cur_pos[2:0]}, data_s1);

			case (phase_d)
				PH_METHOD: begin
					for (int i = 0; i < METHOD_COUNT; i++) begin
						len      = name_len(3'(i));
						bit_mask = 8'(1) << i;
						if (method_alive_d[i] && cur_pos < 5'(len)) begin
							if (data_s1 != name_char(3'(i), cur_pos[2:0])) begin
								method_alive_d = method_alive_d & ~bit_mask;
							end else if (cur_pos + 5'd1 == 5'(len)) begin
								chosen_d = 3'(i);
								phase_d  = PH_SKIP;
							end
						end
					end
					if (phase_d == PH_METHOD && method_alive_d == 8'd0)
						phase_d = PH_FAIL;
				end
				PH_SKIP: begin
					phase_d = PH_SEARCH;
				end
				PH_SEARCH: begin
					if (data_s1 == CHAR_SPACE) begin
						phase_d  = PH_VERSION;
						voff_d   = 4'd0;
						valive_d = 2'b11;
					end
				end
				PH_VERSION: begin
					valive_d = ver_step(valive_d, voff_d, data_s1);
					if (valive_d == 2'b00)
						phase_d = PH_FAIL;
					else if (voff_d >= 4'd7)
						phase_d = PH_MATCH;
					voff_d = voff_d + 4'd1;
				end
				default: begin
				end
			endcase

			// Saturate the position at its top value
			if (pos_d != 5'd31)
				pos_d = pos_d + 5'd1;

			if (last_s1) begin
				res_fire = 1'b1;
				if (cur_pos >= 5'(MIN_LEN - 1)) begin
					if (phase_d == PH_MATCH) begin
						res_verdict = VERDICT_REQUEST;
						res_method  = chosen_d;
					end else if (resp_alive_d != 2'b00) begin
						res_verdict = VERDICT_RESPONSE;
					end
				end
				phase_d = PH_IDLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q          <= 5'd0;
			method_alive_q <= 8'd0;
			chosen_q       <= 3'd0;
			resp_alive_q   <= 2'b00;
			phase_q        <= PH_IDLE;
			voff_q         <= 4'd0;
			valive_q       <= 2'b00;
		end else if (advance) begin
			pos_q          <= pos_d;
			method_alive_q <= method_alive_d;
			chosen_q       <= chosen_d;
			resp_alive_q   <= resp_alive_d;
			phase_q        <= phase_d;
			voff_q         <= voff_d;
			valive_q       <= valive_d;
		end
	end

	// Result register: load a verdict, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && res_fire) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_fire) begin
			verdict_q <= res_verdict;
			method_q  <= res_method;
		end
	end

	assign result_valid = res_valid_q;
	assign verdict      = verdict_q;
	assign method_code  = method_q;

endmodule
`default_nettype wire
